### sv/bpa_pkg.sv
// Package: shared types, codes and command/status structs for the buddy page allocator.
`default_nettype none
package bpa_pkg;
  localparam int MAX_PAGES = 4096;
  localparam int LEVELS    = 13;

  localparam logic [1:0] ACT_FREE   = 2'd0;
  localparam logic [1:0] ACT_ALLOC  = 2'd1;
  localparam logic [1:0] ACT_MERGE  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ALLOC   = 2'd1;
  localparam logic [1:0] ST_NOSPC   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FREE, S_FIND, S_FIND_WAIT, S_FIND_CHK, S_TAKE,
    S_MERGE, S_MERGE_WAIT, S_MERGE_CHK, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;     // clear one map bit
    logic load;         // latch request
    logic free_step;    // one give_run bit
    logic find_start;   // reset find level/page
    logic find_rd;      // read map at find pointer
    logic find_adv;     // move find pointer
    logic take;         // clear found bit, set up tail give_run
    logic merge_start;  // reset merge pointer
    logic merge_act;    // act on read bit, advance
    logic set_nospc;
    logic set_alloc;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic free_done;
    logic find_hit;
    logic find_fail;
    logic merge_last;
    logic need_merge;
    logic zero_count;
    logic [1:0] action;
  } stat_t;
endpackage
`default_nettype wire

### sv/bpa_ctrl.sv
// Controller: sequencer for clear, free, allocate and merge.
`default_nettype none
module bpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          out_fire,
  input  wire bpa_pkg::stat_t st,
  output bpa_pkg::cmd_t       cmd,
  output logic               busy,
  output logic               out_valid
);
  bpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bpa_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      bpa_pkg::S_CLEAR: if (st.clr_done) state_next = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE: if (in_fire) begin
        case (st.action)
          bpa_pkg::ACT_FREE:  state_next = bpa_pkg::S_FREE;
          bpa_pkg::ACT_ALLOC: state_next = bpa_pkg::S_FIND;
          bpa_pkg::ACT_MERGE: state_next = bpa_pkg::S_MERGE;
          default:            state_next = bpa_pkg::S_OUT;
        endcase
      end
      bpa_pkg::S_FREE: if (st.free_done) state_next = bpa_pkg::S_OUT;
      bpa_pkg::S_FIND: begin
        if (st.zero_count || st.find_fail) state_next = bpa_pkg::S_OUT;
        else state_next = bpa_pkg::S_FIND_WAIT;
      end
      bpa_pkg::S_FIND_WAIT: state_next = bpa_pkg::S_FIND_CHK;
      bpa_pkg::S_FIND_CHK: begin
        if (st.find_hit) state_next = bpa_pkg::S_TAKE;
        else state_next = bpa_pkg::S_FIND;
      end
      bpa_pkg::S_TAKE: state_next = st.need_merge ? bpa_pkg::S_FREE : bpa_pkg::S_OUT;
      bpa_pkg::S_MERGE: state_next = bpa_pkg::S_MERGE_WAIT;
      bpa_pkg::S_MERGE_WAIT: state_next = bpa_pkg::S_MERGE_CHK;
      bpa_pkg::S_MERGE_CHK: state_next = st.merge_last ? bpa_pkg::S_OUT : bpa_pkg::S_MERGE;
      bpa_pkg::S_OUT: if (out_fire) state_next = bpa_pkg::S_IDLE;
      default: state_next = bpa_pkg::S_IDLE;
    endcase
    // free followed by merge (tail of allocate)
    if (state == bpa_pkg::S_FREE && st.free_done && st.need_merge)
      state_next = bpa_pkg::S_MERGE;
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state)
      bpa_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      bpa_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
        cmd.find_start = in_fire;
        cmd.merge_start = in_fire;
      end
      bpa_pkg::S_FREE: begin
        cmd.free_step = 1'b1;
        cmd.merge_start = st.free_done;
        cmd.out_load = st.free_done && !st.need_merge;
      end
      bpa_pkg::S_FIND: begin
        cmd.find_rd = !(st.zero_count || st.find_fail);
        cmd.set_nospc = st.zero_count || st.find_fail;
        cmd.out_load = st.zero_count || st.find_fail;
      end
      // keep the read on the find pointer
      bpa_pkg::S_FIND_WAIT: cmd.find_rd = 1'b1;
      bpa_pkg::S_FIND_CHK: cmd.find_adv = !st.find_hit;
      bpa_pkg::S_TAKE: begin
        cmd.take = 1'b1;
        cmd.set_alloc = 1'b1;
        cmd.out_load = !st.need_merge;
      end
      bpa_pkg::S_MERGE_CHK: begin
        cmd.merge_act = 1'b1;
        cmd.out_load = st.merge_last;
      end
      bpa_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### sv/bpa_dp.sv
// Datapath: free-map memory, find and merge pointers, give_run splitter, result register.
`default_nettype none
module bpa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bpa_pkg::cmd_t                 cmd,
  input  wire logic [12:0]                   pool_pages,
  input  wire logic [1:0]                    in_action,
  input  wire logic [11:0]                   in_start,
  input  wire logic [12:0]                   in_count,
  output bpa_pkg::stat_t                     st,
  output logic [1:0]                         out_status,
  output logic [11:0]                        out_page
);
  localparam int MAX_PAGES = bpa_pkg::MAX_PAGES;
  localparam int LEVELS    = bpa_pkg::LEVELS;
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int LW  = $clog2(LEVELS + 1);
  localparam int MD  = LEVELS * MAX_PAGES;
  localparam int AW  = $clog2(MD);

  // one bit per (level, page), level-major; one write and one read a cycle
  logic mem [MD];
  logic rd_bit;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en, wr_val;
  // merge: prev cleared in the cycle after the hit, next-level bit set in the cycle after that
  logic merge_hit;
  logic [AW-1:0] wr2_addr;
  logic wr2_en;
  logic set_up_en;
  logic [AW-1:0] set_up_addr;

  logic [12:0] count;
  logic [PW:0] fstart;     // running start for give_run
  logic [4:0]  glvl;       // give_run level
  logic [12:0] grem;       // give_run remaining count
  logic [LW-1:0] flvl;
  logic [PW:0] fpage;
  logic [LW-1:0] mlvl;
  logic [PW:0] mpage;
  logic have_prev;
  logic [PW-1:0] prev;
  logic [AW:0] clr_ptr;
  logic merge_pend;
  logic [PW-1:0] base;
  logic [1:0] status;
  logic [LW-1:0] nlev;

  function automatic logic [4:0] blen13(input logic [12:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 13; i++) if (v[i]) n = 5'(i + 1);
    return n;
  endfunction

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [PW-1:0] p);
    return AW'(l * MAX_PAGES + p);
  endfunction

  always_comb begin
    nlev = (blen13(pool_pages) > 5'(LEVELS)) ? LW'(LEVELS) : LW'(blen13(pool_pages));
  end

  // adjacent pair at a level in use, below the top level
  assign merge_hit = cmd.merge_act && rd_bit && have_prev && (mlvl < nlev)
                     && mpage == {1'b0, prev} + ((PW+1)'(1) << mlvl)
                     && (32'(mlvl) + 1) < LEVELS;

  // memory write selection
  always_comb begin
    wr_en = 1'b0; wr_val = 1'b0; wr_addr = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1; wr_addr = clr_ptr[AW-1:0];
    end else if (cmd.free_step && grem[0] && fstart < (PW+1)'(MAX_PAGES)
                 && glvl < 5'(LEVELS)) begin
      wr_en = 1'b1; wr_val = 1'b1; wr_addr = addr(LW'(glvl), fstart[PW-1:0]);
    end else if (cmd.take) begin
      wr_en = 1'b1; wr_addr = addr(flvl, fpage[PW-1:0]);
    end else if (merge_hit) begin
      wr_en = 1'b1; wr_addr = addr(mlvl, mpage[PW-1:0]);
    end else if (wr2_en) begin
      wr_en = 1'b1; wr_addr = wr2_addr;
    end else if (set_up_en) begin
      wr_en = 1'b1; wr_val = 1'b1; wr_addr = set_up_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_val;
    rd_bit <= (wr_en && wr_addr == rd_addr) ? wr_val : mem[rd_addr];
  end

  assign rd_addr = cmd.find_rd ? addr(flvl, fpage[PW-1:0]) : addr(mlvl, mpage[PW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      wr2_en <= 1'b0;
      set_up_en <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_ptr <= clr_ptr + 1'b1;
      wr2_en <= merge_hit;
      set_up_en <= wr2_en;
    end
    if (merge_hit) begin
      wr2_addr <= addr(mlvl, prev);
      set_up_addr <= addr(mlvl + 1'b1, prev);
    end

    if (cmd.load) begin
      count  <= in_count;
      fstart <= {1'b0, in_start};
      grem   <= in_count;
      glvl   <= '0;
      merge_pend <= 1'b0;
      status <= bpa_pkg::ST_DONE;
      base <= '0;
      out_status <= bpa_pkg::ST_DONE;
      out_page <= '0;
    end
    if (cmd.find_start) begin
      flvl <= LW'(blen13(in_count - 13'd1));
      fpage <= '0;
    end
    if (cmd.find_adv) begin
      if (fpage == (PW+1)'(MAX_PAGES - 1)) begin
        fpage <= '0; flvl <= flvl + 1'b1;
      end else fpage <= fpage + 1'b1;
    end
    if (cmd.free_step) begin
      if (grem[0]) fstart <= fstart + ((PW+1)'(1) << glvl);
      grem <= grem >> 1;
      glvl <= glvl + 1'b1;
    end
    if (cmd.take) begin
      base <= fpage[PW-1:0];
      fstart <= fpage + (PW+1)'(count);
      grem <= 13'((14'd1 << flvl) - 14'(count));
      glvl <= '0;
      merge_pend <= ((14'd1 << flvl) != 14'(count));
    end
    if (cmd.merge_start) begin
      mlvl <= '0; mpage <= '0; have_prev <= 1'b0; prev <= '0;
    end
    if (cmd.merge_act) begin
      if (rd_bit) begin
        if (merge_hit) have_prev <= 1'b0;
        else begin prev <= mpage[PW-1:0]; have_prev <= 1'b1; end
      end
      if (mpage == (PW+1)'(MAX_PAGES - 1)) begin
        mpage <= '0; mlvl <= mlvl + 1'b1; have_prev <= 1'b0;
      end else mpage <= mpage + 1'b1;
    end
    if (cmd.set_nospc) status <= bpa_pkg::ST_NOSPC;
    if (cmd.set_alloc) status <= bpa_pkg::ST_ALLOC;
    if (cmd.out_load) begin
      out_status <= cmd.set_nospc ? bpa_pkg::ST_NOSPC :
                    cmd.set_alloc ? bpa_pkg::ST_ALLOC : status;
      out_page <= cmd.set_alloc ? 12'(fpage) :
                  (status == bpa_pkg::ST_ALLOC && !cmd.set_nospc) ? 12'(base) : '0;
    end
  end

  always_comb begin
    st.clr_done = (clr_ptr == (AW+1)'(MD - 1));
    st.free_done = (grem == '0) || (glvl == 5'd31) || (cmd.free_step && (grem >> 1) == '0);
    st.find_hit = rd_bit;
    st.find_fail = (flvl >= nlev);
    st.merge_last = (mpage == (PW+1)'(MAX_PAGES - 1)) && ((mlvl + 1'b1) >= nlev);
    st.need_merge = cmd.take ? ((14'd1 << flvl) != 14'(count)) : merge_pend;
    st.zero_count = (count == '0);
    st.action = in_action;
  end
endmodule
`default_nettype wire

### sv/buddy_page_allocator.sv
// Top level: buddy page allocator with stream request/response ports.
// Free marks the range free as one block per set bit of count; merge reads, waits for and
// checks each page over the levels in use; allocate scans pages from the rounded-up level
// (refused if count is zero or no level in use is left), then frees the tail and merges.
// One request at a time; the next is taken in the cycle after the result is taken.
// Reset: synchronous; the free map is cleared first; pool_pages returns to 4096.
`default_nettype none
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // action[1:0], start_page[13:2], page_count[26:14]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // status[1:0], block_page[13:2]
);
  logic [12:0] pool_pages;
  bpa_pkg::cmd_t cmd;
  bpa_pkg::stat_t st;
  logic busy, in_fire, out_fire;
  logic [1:0] o_status;
  logic [11:0] o_page;

  always_ff @(posedge clk) begin
    if (rst) pool_pages <= 13'd4096;
    else if (cfg_we) pool_pages <= cfg_wdata;
  end

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  bpa_ctrl u_ctrl (.clk, .rst, .in_fire, .out_fire, .st, .cmd, .busy, .out_valid(m_tvalid));

  bpa_dp u_dp (
    .clk, .rst, .cmd, .pool_pages,
    .in_action(s_tdata[1:0]), .in_start(s_tdata[13:2]), .in_count(s_tdata[26:14]),
    .st, .out_status(o_status), .out_page(o_page));

  assign m_tdata = {2'b00, o_page, o_status};

  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("request taken while result pending");
  // page is zero unless allocated
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != bpa_pkg::ST_ALLOC) |-> m_tdata[13:2] == '0)
    else $error("block_page nonzero");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result changed under stall");
endmodule
`default_nettype wire
